@@ sv/assert_macros.svh @@
// Assertion macros shared by the notch filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, masked while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/inf_pkg.sv @@
// Package: shared types, constants and helpers of the order-4 notch filter.
package inf_pkg;

    // Filter structure
    localparam int ORDER         = 4;
    localparam int NUM_MAC_STEPS = 2 * ORDER + 1;
    localparam int STEP_W        = $clog2(NUM_MAC_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_MAC_STEPS);
    localparam logic [STEP_W-1:0] STEP_FIRST_FB = STEP_W'(ORDER + 1);

    // Default widths
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Register file
    localparam int NUM_COEFS  = 7;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_NUM_C0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_C1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_C2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEN_C1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEN_C2 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEN_C3 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DEN_C4 = 3'd6;

    // Notch defaults in Q2.16
    localparam int COEF_RESET_FRAC = 16;
    localparam int COEF_RESET_Q16 [NUM_COEFS] = '{
        59021, -14866, 118977, -15630, 118075, -14045, 52950
    };

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } inf_state_t;

    // Control from the sequencer to the MAC
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
        logic sub;
    } mac_ctl_t;

    // Default coefficient rescaled to the configured fraction width
    function automatic logic signed [31:0] coef_reset(input int idx, input int frac);
        int v;
        v = COEF_RESET_Q16[idx];
        if (frac >= COEF_RESET_FRAC)
            return 32'(v <<< (frac - COEF_RESET_FRAC));
        else
            return 32'(v >>> (COEF_RESET_FRAC - frac));
    endfunction

endpackage

@@ sv/inf_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
module inf_mac #(
    parameter int SAMPLE_BITS    = inf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = inf_pkg::COEF_FRAC_BITS_DEF,
    parameter int COEF_W         = COEF_FRAC_BITS + 2,
    parameter int ACC_W          = SAMPLE_BITS + COEF_W + 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  inf_pkg::mac_ctl_t        ctl,
    input  logic signed [SAMPLE_BITS-1:0] op_sample,
    input  logic signed [COEF_W-1:0]      op_coef,
    output logic signed [ACC_W-1:0]       acc_sum
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    // Multiplier stage; operands sign-extended to the product width
    assign prod_next = PROD_W'(op_sample) * PROD_W'(op_coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else if (ctl.mul_en)
        begin
            sub_reg <= ctl.sub;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate stage; the sum is also the final value on the last step
    assign prod_ext = ACC_W'(prod_reg);
    assign acc_sum  = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= ROUND_HALF;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_sum;
        end
    end

endmodule

@@ sv/iir_notch_filter_order4.sv @@
// Top level: order-4 direct-form-I IIR notch filter with one shared MAC.
// A new sample is accepted only while the sequencer is idle. Each sample takes
//   nine passes through the single multiplier-accumulator plus the final
//   round/saturate step, which waits while a pending result is stalled.
// Reset: coefficients return to the notch defaults, both histories clear to zero,
//   no output is pending.
`include "assert_macros.svh"

module iir_notch_filter_order4 #(
    parameter int SAMPLE_BITS    = inf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = inf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    output logic                              clipped,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [inf_pkg::PADDR_W-1:0]       paddr,
    input  logic [inf_pkg::PDATA_W-1:0]       pwdata,
    output logic [inf_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int ACC_W  = SAMPLE_BITS + COEF_W + 4;
    localparam int HI_W   = ACC_W - SAMPLE_BITS + 1;
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic signed [COEF_W-1:0] RST_NUM_C0 =
        COEF_W'(inf_pkg::coef_reset(0, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_NUM_C1 =
        COEF_W'(inf_pkg::coef_reset(1, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_NUM_C2 =
        COEF_W'(inf_pkg::coef_reset(2, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_DEN_C1 =
        COEF_W'(inf_pkg::coef_reset(3, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_DEN_C2 =
        COEF_W'(inf_pkg::coef_reset(4, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_DEN_C3 =
        COEF_W'(inf_pkg::coef_reset(5, COEF_FRAC_BITS));
    localparam logic signed [COEF_W-1:0] RST_DEN_C4 =
        COEF_W'(inf_pkg::coef_reset(6, COEF_FRAC_BITS));

    // Coefficient registers
    logic signed [COEF_W-1:0] num_c0_reg, num_c1_reg, num_c2_reg;
    logic signed [COEF_W-1:0] den_c1_reg, den_c2_reg, den_c3_reg, den_c4_reg;

    // Sequencer and data state
    inf_pkg::inf_state_t               state_reg, state_next;
    logic [inf_pkg::STEP_W-1:0]        step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0]     x0_reg;
    logic signed [SAMPLE_BITS-1:0]     xh_reg [inf_pkg::ORDER];
    logic signed [SAMPLE_BITS-1:0]     yh_reg [inf_pkg::ORDER];
    logic                              out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]     sample_out_reg;
    logic                              clipped_reg;

    logic                              in_xfer;
    logic                              finish;
    logic                              cfg_wr;
    logic [inf_pkg::REG_IDX_W-1:0]     cfg_idx;
    logic signed [COEF_W-1:0]          cfg_coef;
    logic [inf_pkg::PDATA_W-1:0]       rd_data;
    inf_pkg::mac_ctl_t                 mac_ctl;
    logic signed [SAMPLE_BITS-1:0]     op_sample;
    logic signed [COEF_W-1:0]          op_coef;
    logic signed [ACC_W-1:0]           acc_sum;
    logic signed [ACC_W-1:0]           acc_shift;
    logic [HI_W-1:0]                   acc_hi;
    logic                              ovf;
    logic signed [SAMPLE_BITS-1:0]     y_sat;

    // Register port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[inf_pkg::PADDR_W-1:2];
    assign cfg_coef = pwdata[COEF_W-1:0];
    assign prdata   = rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_c0_reg <= RST_NUM_C0;
            num_c1_reg <= RST_NUM_C1;
            num_c2_reg <= RST_NUM_C2;
            den_c1_reg <= RST_DEN_C1;
            den_c2_reg <= RST_DEN_C2;
            den_c3_reg <= RST_DEN_C3;
            den_c4_reg <= RST_DEN_C4;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                inf_pkg::REG_NUM_C0: num_c0_reg <= cfg_coef;
                inf_pkg::REG_NUM_C1: num_c1_reg <= cfg_coef;
                inf_pkg::REG_NUM_C2: num_c2_reg <= cfg_coef;
                inf_pkg::REG_DEN_C1: den_c1_reg <= cfg_coef;
                inf_pkg::REG_DEN_C2: den_c2_reg <= cfg_coef;
                inf_pkg::REG_DEN_C3: den_c3_reg <= cfg_coef;
                inf_pkg::REG_DEN_C4: den_c4_reg <= cfg_coef;
                default: ;
            endcase
        end
    end

    // Readback, sign-extended
    always_comb
    begin
        unique case (cfg_idx)
            inf_pkg::REG_NUM_C0: rd_data = inf_pkg::PDATA_W'(num_c0_reg);
            inf_pkg::REG_NUM_C1: rd_data = inf_pkg::PDATA_W'(num_c1_reg);
            inf_pkg::REG_NUM_C2: rd_data = inf_pkg::PDATA_W'(num_c2_reg);
            inf_pkg::REG_DEN_C1: rd_data = inf_pkg::PDATA_W'(den_c1_reg);
            inf_pkg::REG_DEN_C2: rd_data = inf_pkg::PDATA_W'(den_c2_reg);
            inf_pkg::REG_DEN_C3: rd_data = inf_pkg::PDATA_W'(den_c3_reg);
            inf_pkg::REG_DEN_C4: rd_data = inf_pkg::PDATA_W'(den_c4_reg);
            default:             rd_data = '0;
        endcase
    end

    // Handshakes
    assign in_stall = (state_reg != inf_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign finish   = (state_reg == inf_pkg::ST_RUN) && (step_reg == inf_pkg::STEP_LAST)
                      && !(out_valid_reg && out_stall);

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= inf_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Sequencer next state and MAC control
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mac_ctl.clear  = 1'b0;
        mac_ctl.mul_en = 1'b0;
        mac_ctl.acc_en = 1'b0;
        mac_ctl.sub    = 1'b0;
        unique case (state_reg)
            inf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next    = inf_pkg::ST_RUN;
                    step_next     = '0;
                    mac_ctl.clear = 1'b1;
                end
            end
            inf_pkg::ST_RUN:
            begin
                mac_ctl.mul_en = (step_reg < inf_pkg::STEP_LAST);
                mac_ctl.acc_en = (step_reg != '0) && (step_reg < inf_pkg::STEP_LAST);
                mac_ctl.sub    = (step_reg >= inf_pkg::STEP_FIRST_FB);
                if (step_reg < inf_pkg::STEP_LAST)
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (finish)
                begin
                    state_next = inf_pkg::ST_IDLE;
                    step_next  = '0;
                end
            end
            default:
            begin
                state_next = inf_pkg::ST_IDLE;
            end
        endcase
    end

    // Operand select per step: five feed-forward taps, then four feedback taps
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin op_sample = x0_reg;    op_coef = num_c0_reg; end
            4'd1:    begin op_sample = xh_reg[0]; op_coef = num_c1_reg; end
            4'd2:    begin op_sample = xh_reg[1]; op_coef = num_c2_reg; end
            4'd3:    begin op_sample = xh_reg[2]; op_coef = num_c1_reg; end
            4'd4:    begin op_sample = xh_reg[3]; op_coef = num_c0_reg; end
            4'd5:    begin op_sample = yh_reg[0]; op_coef = den_c1_reg; end
            4'd6:    begin op_sample = yh_reg[1]; op_coef = den_c2_reg; end
            4'd7:    begin op_sample = yh_reg[2]; op_coef = den_c3_reg; end
            4'd8:    begin op_sample = yh_reg[3]; op_coef = den_c4_reg; end
            default: begin op_sample = '0;        op_coef = '0;         end
        endcase
    end

    inf_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COEF_W         (COEF_W),
        .ACC_W          (ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .op_sample (op_sample),
        .op_coef   (op_coef),
        .acc_sum   (acc_sum)
    );

    // Drop the fraction (rounding bias already in the accumulator), then saturate
    assign acc_shift = acc_sum >>> COEF_FRAC_BITS;
    assign acc_hi    = acc_shift[ACC_W-1:SAMPLE_BITS-1];
    assign ovf       = !((&acc_hi) || !(|acc_hi));
    assign y_sat     = ovf ? (acc_shift[ACC_W-1] ? SAT_MIN : SAT_MAX)
                           : acc_shift[SAMPLE_BITS-1:0];

    // Sample latch and histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_reg <= '0;
            for (int i = 0; i < inf_pkg::ORDER; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_xfer)
            begin
                x0_reg <= sample_in;
            end
            if (finish)
            begin
                for (int i = inf_pkg::ORDER - 1; i > 0; i--)
                begin
                    xh_reg[i] <= xh_reg[i-1];
                    yh_reg[i] <= yh_reg[i-1];
                end
                xh_reg[0] <= x0_reg;
                yh_reg[0] <= y_sat;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sample_out_reg <= y_sat;
            clipped_reg    <= ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    // Checks
    `ASSERT_CLK(a_accept_starts_run, in_xfer |=> (state_reg == inf_pkg::ST_RUN && step_reg == '0), "accepted sample did not start the MAC sequence")
    `ASSERT_CLK(a_step_bound, (state_reg == inf_pkg::ST_RUN) |-> (step_reg <= inf_pkg::STEP_LAST), "step counter ran past the last MAC step")
    `ASSERT_CLK(a_out_after_last, $rose(out_valid) |-> $past(state_reg == inf_pkg::ST_RUN && step_reg == inf_pkg::STEP_LAST), "result appeared without a finished sequence")
    `ASSERT_CLK(a_clip_extreme, (out_valid && clipped) |-> (sample_out == SAT_MAX || sample_out == SAT_MIN), "clipped result is not a rail value")
    `ASSERT_ALWAYS(a_idle_no_stall, (state_reg == inf_pkg::ST_IDLE) |-> !in_stall, "input stalled while sequencer idle")

endmodule

@@ test/iir_notch_checker.sv @@
// Checker for the order-4 notch filter: watches both channels, predicts each sample, compares.
`timescale 1ns / 1ps

module iir_notch_checker #(
    parameter int SAMPLE_BITS    = inf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = inf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          clipped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [inf_pkg::PADDR_W-1:0]   paddr,
    input  logic [inf_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            clip_count
);

    localparam int     COEF_W = COEF_FRAC_BITS + 2;
    localparam longint SMAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMIN   = -SMAX - 1;

    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    clip;
    } filt_result_t;

    // Mirror of the coefficient registers
    coef_t num_c0, num_c1, num_c2;
    coef_t den_c1, den_c2, den_c3, den_c4;

    // Past inputs and saturated outputs, index 0 is one sample back
    sample_t x_hist [4];
    sample_t y_hist [4];

    filt_result_t expected_q [$];

    // One line per mismatch, counted
    task automatic report_mismatch(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_count++;
    endtask

    // Direct-form-I sum, round half up, shift, saturate
    function automatic filt_result_t filter_sample(input sample_t x0);
        longint       acc;
        longint       y;
        filt_result_t r;
        acc = longint'(num_c0) * longint'(x0)
            + longint'(num_c1) * longint'(x_hist[0])
            + longint'(num_c2) * longint'(x_hist[1])
            + longint'(num_c1) * longint'(x_hist[2])
            + longint'(num_c0) * longint'(x_hist[3])
            - longint'(den_c1) * longint'(y_hist[0])
            - longint'(den_c2) * longint'(y_hist[1])
            - longint'(den_c3) * longint'(y_hist[2])
            - longint'(den_c4) * longint'(y_hist[3]);
        acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;
        r.clip = 1'b0;
        if (y > SMAX)
        begin
            y = SMAX;
            r.clip = 1'b1;
        end
        else if (y < SMIN)
        begin
            y = SMIN;
            r.clip = 1'b1;
        end
        r.sample = SAMPLE_BITS'(y);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        coef_t        wval;
        if (!rst_n)
        begin
            num_c0 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C0]);
            num_c1 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C1]);
            num_c2 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C2]);
            den_c1 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C1]);
            den_c2 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C2]);
            den_c3 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C3]);
            den_c4 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C4]);
            for (int i = 0; i < 4; i++)
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            expected_q.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
            clip_count   = 0;
        end
        else
        begin
            // Register write; bits above the coefficient width drop out
            if (psel && penable && pwrite && pready)
            begin
                wval = pwdata[COEF_W-1:0];
                case (paddr[inf_pkg::PADDR_W-1:2])
                    inf_pkg::REG_NUM_C0: num_c0 = wval;
                    inf_pkg::REG_NUM_C1: num_c1 = wval;
                    inf_pkg::REG_NUM_C2: num_c2 = wval;
                    inf_pkg::REG_DEN_C1: den_c1 = wval;
                    inf_pkg::REG_DEN_C2: den_c2 = wval;
                    inf_pkg::REG_DEN_C3: den_c3 = wval;
                    inf_pkg::REG_DEN_C4: den_c4 = wval;
                    default: ;
                endcase
            end

            // Output transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected: sample_out %0d",
                                              result_count, sample_out));
                else
                begin
                    want = expected_q.pop_front();
                    if (want.clip)
                        clip_count++;
                    if (sample_out !== want.sample)
                        report_mismatch($sformatf("result %0d sample_out got %0d want %0d",
                                                  result_count, sample_out, want.sample));
                    if (clipped !== want.clip)
                        report_mismatch($sformatf("result %0d clipped got %b want %b",
                                                  result_count, clipped, want.clip));
                end
            end

            // Input transfer: predict, then shift the histories
            if (in_valid && !in_stall)
            begin
                want = filter_sample(sample_in);
                for (int i = 3; i > 0; i--)
                begin
                    x_hist[i] = x_hist[i-1];
                    y_hist[i] = y_hist[i-1];
                end
                x_hist[0] = sample_in;
                y_hist[0] = want.sample;
                expected_q.push_back(want);
            end

            pending = expected_q.size();
        end
    end

endmodule

@@ test/tb_iir_notch_filter_order4.sv @@
// Testbench top for the order-4 notch filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_iir_notch_filter_order4;

    localparam int SW             = inf_pkg::SAMPLE_BITS_DEF;
    localparam int COEF_W         = inf_pkg::COEF_FRAC_BITS_DEF + 2;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 138;

    localparam logic [inf_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [SW-1:0]     S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]     S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] C_HALF = COEF_W'(1 << (inf_pkg::COEF_FRAC_BITS_DEF - 1));

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct {
        coef_t num_c0, num_c1, num_c2;
        coef_t den_c1, den_c2, den_c3, den_c4;
    } coef_set_t;

    typedef enum {SET_NOTCH, SET_RANDOM, SET_FIR, SET_CORNER} coef_kind_t;
    typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic signed [SW-1:0]   sample_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [SW-1:0]   sample_out;
    logic                   clipped;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [inf_pkg::PADDR_W-1:0] paddr  = '0;
    logic [inf_pkg::PDATA_W-1:0] pwdata = '0;
    logic [inf_pkg::PDATA_W-1:0] prdata;
    logic                   pready;

    int fail_count, pending, result_count, clip_count;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    logic hold_req   = 1'b0;
    int hold_count   = 0;
    int n_sent       = 0;
    int n_writes     = 0;
    int n_sets       = 0;

    always #10 clk = ~clk;

    iir_notch_filter_order4 i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .clipped    (clipped),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    iir_notch_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .clipped      (clipped),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .clip_count   (clip_count)
    );

    // Receiver: one long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Called and returning at a falling edge; leaves in_valid high
    task automatic send_sample(input logic signed [SW-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            sample_in <= SW'($urandom());
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= v;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
        @(negedge clk);
    endtask

    // Setup then access cycle; leaves psel high for a following write
    task automatic write_reg(input logic [inf_pkg::REG_IDX_W-1:0] idx, input coef_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(inf_pkg::PDATA_W-COEF_W)'($urandom()), v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        n_writes++;
        @(negedge clk);
    endtask

    task automatic load_coefs(input coef_set_t c);
        write_reg(inf_pkg::REG_NUM_C0, c.num_c0);
        write_reg(inf_pkg::REG_NUM_C1, c.num_c1);
        write_reg(inf_pkg::REG_NUM_C2, c.num_c2);
        write_reg(inf_pkg::REG_DEN_C1, c.den_c1);
        write_reg(inf_pkg::REG_DEN_C2, c.den_c2);
        write_reg(inf_pkg::REG_DEN_C3, c.den_c3);
        write_reg(inf_pkg::REG_DEN_C4, c.den_c4);
        // out-of-range index must leave every coefficient alone
        write_reg(REG_UNUSED, coef_t'($urandom()));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_sets++;
    endtask

    // Drop valid, wait for all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idle(input idle_mode_t m);
        case (m)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            IDLE_TX:   begin tx_idle_pct = 82; rx_stall_pct <= 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct <= 82; end
            default:   begin tx_idle_pct = 30; rx_stall_pct <= 30; end
        endcase
    endtask

    function automatic coef_t corner_coef();
        case ($urandom_range(4))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return coef_t'(1);
            default: return coef_t'(-1);
        endcase
    endfunction

    function automatic coef_set_t notch_set();
        coef_set_t c;
        c.num_c0 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C0]);
        c.num_c1 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C1]);
        c.num_c2 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_NUM_C2]);
        c.den_c1 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C1]);
        c.den_c2 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C2]);
        c.den_c3 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C3]);
        c.den_c4 = COEF_W'(inf_pkg::COEF_RESET_Q16[inf_pkg::REG_DEN_C4]);
        return c;
    endfunction

    function automatic coef_set_t uniform_set(input coef_t v);
        coef_set_t c;
        c.num_c0 = v; c.num_c1 = v; c.num_c2 = v;
        c.den_c1 = v; c.den_c2 = v; c.den_c3 = v; c.den_c4 = v;
        return c;
    endfunction

    function automatic coef_set_t pick_coefs(input coef_kind_t kind);
        coef_set_t c;
        case (kind)
            SET_NOTCH: c = notch_set();
            SET_RANDOM:
            begin
                c.num_c0 = coef_t'($urandom()); c.num_c1 = coef_t'($urandom());
                c.num_c2 = coef_t'($urandom()); c.den_c1 = coef_t'($urandom());
                c.den_c2 = coef_t'($urandom()); c.den_c3 = coef_t'($urandom());
                c.den_c4 = coef_t'($urandom());
            end
            SET_FIR:
            begin
                // no feedback: outputs track the inputs, clipping only on peaks
                c = uniform_set('0);
                c.num_c0 = coef_t'($urandom()) >>> 2;
                c.num_c1 = coef_t'($urandom()) >>> 2;
                c.num_c2 = coef_t'($urandom()) >>> 2;
            end
            default:
            begin
                c.num_c0 = corner_coef(); c.num_c1 = corner_coef();
                c.num_c2 = corner_coef(); c.den_c1 = corner_coef();
                c.den_c2 = corner_coef(); c.den_c3 = corner_coef();
                c.den_c4 = corner_coef();
            end
        endcase
        return c;
    endfunction

    // Mostly full-range samples, some near zero, some at full scale
    function automatic logic signed [SW-1:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return SW'($urandom());
        else if (r < 85)
            return SW'($signed(9'($urandom())));
        else
            return $urandom_range(1) ? S_MAX : S_MIN;
    endfunction

    initial
    begin
        coef_set_t  c;
        coef_kind_t kind;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset coefficients, zero and full-scale inputs
        set_idle(IDLE_NONE);
        send_sample('0);
        send_sample(SW'(1));
        send_sample(SW'(-1));
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample('0);
        send_sample('0);
        send_sample('0);
        drain();

        // Directed: gain one half, exact half LSB rounds upward
        c = uniform_set('0);
        c.num_c0 = C_HALF;
        load_coefs(c);
        send_sample(SW'(1));
        send_sample(SW'(-1));
        send_sample(SW'(3));
        send_sample(SW'(-3));
        send_sample(S_MAX);
        send_sample(S_MIN);
        drain();

        // Directed: all coefficients at the extremes, saturation both ways
        load_coefs(uniform_set(C_MAX));
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
        drain();
        load_coefs(uniform_set(C_MIN));
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample('0);
        send_sample(S_MIN);
        drain();

        // Random phases across coefficient kinds and idle patterns
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            kind = coef_kind_t'((p + p / 4) % 4);
            load_coefs(pick_coefs(kind));
            set_idle(idle_mode_t'(p % 4));
            // first phase: output held off while input keeps coming
            if (p == 0)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS) send_sample(rand_sample());
            drain();
        end

        // Restore the notch and run a tail at full rate
        load_coefs(notch_set());
        set_idle(IDLE_NONE);
        repeat (20) send_sample(rand_sample());
        drain();

        $display("run covered %0d samples, %0d results (%0d saturated)",
                 n_sent, result_count, clip_count);
        $display("%0d coefficient sets via %0d register writes, one %0d-cycle output hold-off",
                 n_sets, n_writes, HOLD_CYCLES);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
